/* src/ise_pkg.sv */
// Shared constants and types for the index sort engine.
package ise_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_W = 32;
    localparam int POS_W = 6;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_LATCH,
        ST_CMP,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } seq_state_t;

endpackage

/* src/ise_ram.sv */
// Simple dual-port memory with one write port and one registered read port.
module ise_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* src/ise_cmp.sv */
// Shared compare unit ordering two entries by signed key, then by position.
module ise_cmp #(
    parameter int IDX_W = 6
) (
    input  logic signed [ise_pkg::KEY_W-1:0] key_a,
    input  logic [IDX_W-1:0]                 pos_a,
    input  logic signed [ise_pkg::KEY_W-1:0] key_b,
    input  logic [IDX_W-1:0]                 pos_b,
    output logic                             a_before_b
);

    import ise_pkg::*;

    always_comb
    begin
        if (key_a != key_b)
        begin
            a_before_b = key_a < key_b;
        end
        else
        begin
            a_before_b = pos_a < pos_b;
        end
    end

endmodule

/* src/ise_seq.sv */
// Sequencer that loads keys, ranks each one against all others and emits positions.
module ise_seq #(
    parameter int MAX_ITEMS = ise_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic                               m_tlast,
    output logic                               m_tuser,
    output logic                               key_we,
    output logic [$clog2(MAX_ITEMS)-1:0]       key_waddr,
    output logic [$clog2(MAX_ITEMS)-1:0]       key_raddr,
    input  logic signed [ise_pkg::KEY_W-1:0]   key_rdata,
    output logic                               ord_we,
    output logic [$clog2(MAX_ITEMS)-1:0]       ord_waddr,
    output logic [$clog2(MAX_ITEMS)-1:0]       ord_wdata,
    output logic [$clog2(MAX_ITEMS)-1:0]       ord_raddr,
    output logic signed [ise_pkg::KEY_W-1:0]   cmp_key_a,
    output logic [$clog2(MAX_ITEMS)-1:0]       cmp_pos_a,
    output logic signed [ise_pkg::KEY_W-1:0]   cmp_key_b,
    output logic [$clog2(MAX_ITEMS)-1:0]       cmp_pos_b,
    input  logic                               cmp_before
);

    import ise_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    seq_state_t state_reg, state_next;

    logic [CW-1:0]           count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [AW-1:0]           i_reg, i_next;
    logic [AW-1:0]           j_reg, j_next;
    logic [AW-1:0]           rank_reg, rank_next;
    logic [AW-1:0]           k_reg, k_next;
    logic signed [KEY_W-1:0] cur_key_reg, cur_key_next;

    logic          in_acc;
    logic          out_acc;
    logic          room;
    logic [AW-1:0] last_idx;
    logic [AW-1:0] rank_final;

    assign in_acc     = s_tvalid && s_tready;
    assign out_acc    = m_tvalid && m_tready;
    assign room       = count_reg < CW'(MAX_ITEMS);
    assign last_idx   = AW'(count_reg - CW'(1));
    assign rank_final = rank_reg + AW'(cmp_before);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && s_tlast)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (j_reg == last_idx)
                begin
                    state_next = (i_reg == last_idx) ? ST_EMIT_RD : ST_FETCH;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_acc)
                begin
                    state_next = (k_reg == last_idx) ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        key_raddr = '0;
        ord_we    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
            end
            ST_FETCH:
            begin
                key_raddr = i_reg;
            end
            ST_LATCH:
            begin
                key_raddr = '0;
            end
            ST_CMP:
            begin
                key_raddr = j_reg + AW'(1);
                ord_we    = j_reg == last_idx;
            end
            ST_EMIT_RD:
            begin
                m_tvalid = 1'b0;
            end
            ST_EMIT_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign key_we    = in_acc && room;
    assign key_waddr = count_reg[AW-1:0];
    assign ord_waddr = rank_final;
    assign ord_wdata = i_reg;
    assign ord_raddr = k_reg;
    assign m_tlast   = k_reg == last_idx;
    assign m_tuser   = ovf_reg;
    assign cmp_key_a = key_rdata;
    assign cmp_pos_a = j_reg;
    assign cmp_key_b = cur_key_reg;
    assign cmp_pos_b = i_reg;

    always_comb
    begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        rank_next    = rank_reg;
        k_next       = k_reg;
        cur_key_next = cur_key_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                i_next = '0;
                k_next = '0;
            end
            ST_LATCH:
            begin
                cur_key_next = key_rdata;
                j_next       = '0;
                rank_next    = '0;
            end
            ST_CMP:
            begin
                rank_next = rank_final;
                j_next    = j_reg + AW'(1);
                if (j_reg == last_idx)
                begin
                    i_next = i_reg + AW'(1);
                end
            end
            ST_EMIT_OUT:
            begin
                if (out_acc)
                begin
                    k_next = k_reg + AW'(1);
                    if (k_reg == last_idx)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        rank_reg    <= rank_next;
        k_reg       <= k_next;
        cur_key_reg <= cur_key_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("loaded count above capacity");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> rank_reg <= j_reg)
        else $error("rank exceeds number of keys compared");

    a_set_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_LOAD |-> count_reg != '0)
        else $error("sorting an empty set");

endmodule

/* src/index_sort_engine.sv */
// Index sort engine: loads a set of keys and returns their positions in ascending key order.
// Words are loaded in the load state. After the word marked last, every key is ranked by one
// shared comparator against every stored key, read in turn through the single key memory
// read port. Each result is emitted in two steps, order memory read then output.
// No new word is taken while a set is being ranked or emitted.
// Reset (rst_n, asynchronous, active low) empties the set; the memories are not cleared.
module index_sort_engine #(
    parameter int MAX_ITEMS = ise_pkg::MAX_ITEMS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ise_pkg::KEY_W-1:0]       s_tdata,  // [31:0] key
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ise_pkg::OUT_DATA_W-1:0]  m_tdata,  // [5:0] position, [7:6] zero
    output logic                            m_tlast,
    output logic                            m_tuser   // [0] overflowed
);

    import ise_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);

    logic                    key_we;
    logic [AW-1:0]           key_waddr;
    logic [AW-1:0]           key_raddr;
    logic [KEY_W-1:0]        key_rdata;
    logic                    ord_we;
    logic [AW-1:0]           ord_waddr;
    logic [AW-1:0]           ord_wdata;
    logic [AW-1:0]           ord_raddr;
    logic [AW-1:0]           ord_rdata;
    logic signed [KEY_W-1:0] cmp_key_a;
    logic [AW-1:0]           cmp_pos_a;
    logic signed [KEY_W-1:0] cmp_key_b;
    logic [AW-1:0]           cmp_pos_b;
    logic                    cmp_before;

    ise_ram #(
        .DEPTH(MAX_ITEMS),
        .WIDTH(KEY_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (s_tdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    ise_ram #(
        .DEPTH(MAX_ITEMS),
        .WIDTH(AW)
    ) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    ise_cmp #(
        .IDX_W(AW)
    ) u_cmp (
        .key_a      (cmp_key_a),
        .pos_a      (cmp_pos_a),
        .key_b      (cmp_key_b),
        .pos_b      (cmp_pos_b),
        .a_before_b (cmp_before)
    );

    ise_seq #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .key_we     (key_we),
        .key_waddr  (key_waddr),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata),
        .ord_we     (ord_we),
        .ord_waddr  (ord_waddr),
        .ord_wdata  (ord_wdata),
        .ord_raddr  (ord_raddr),
        .cmp_key_a  (cmp_key_a),
        .cmp_pos_a  (cmp_pos_a),
        .cmp_key_b  (cmp_key_b),
        .cmp_pos_b  (cmp_pos_b),
        .cmp_before (cmp_before)
    );

    assign m_tdata = OUT_DATA_W'(POS_W'(ord_rdata));

endmodule
